FILE: sv/assert_macros.svh
// assertion macros for the keyed list rtl
// empty bodies when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define KL_ASSERT(label, prop, msg)
`define KL_NEVER(label, cond, msg)
`endif
`endif

FILE: sv/kl_pkg.sv
// shared types, codes and sizes for the keyed list with index shift
// no dependencies
package kl_pkg;

  localparam int DEPTH   = 64;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;
  localparam int KEY_W   = 16;
  localparam int POS_W   = 16;

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_FIND   = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_SHIFT  = 3'd3,
    REQ_READ   = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_OOR  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // per cell load controls
  typedef struct packed {
    logic load_new;
    logic load_next;
    logic live;
  } cell_ctl_t;

  // data broadcast to every cell
  typedef struct packed {
    logic             shift_on;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] amount;
  } cell_bcast_t;

  // bits below n set
  function automatic logic [DEPTH-1:0] low_mask(input int n);
    logic [DEPTH-1:0] m;
    m = '0;
    for (int j = 0; j < DEPTH; j++) begin
      m[j] = (j < n);
    end
    return m;
  endfunction

endpackage

FILE: sv/kl_cell.sv
// one cell: key, position; loads new or from upper neighbor, or shifts pos
// depends on kl_pkg
module kl_cell
  import kl_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  cell_bcast_t      bc,
  input  logic [KEY_W-1:0] probe,
  input  logic [KEY_W-1:0] next_key,
  input  logic [POS_W-1:0] next_pos,
  output logic [KEY_W-1:0] key,
  output logic [POS_W-1:0] pos,
  output logic             hit
);

  assign hit = (key == probe);

  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      key <= bc.key;
      pos <= bc.pos;
    end else if (ctl.load_next) begin
      key <= next_key;
      pos <= next_pos;
    end else if (bc.shift_on && ctl.live && (pos > bc.pos)) begin
      pos <= pos + bc.amount;
    end
  end

endmodule

FILE: sv/kl_prio.sv
// lowest match finder over the cell chain match vector
// depends on kl_pkg
module kl_prio
  import kl_pkg::*;
(
  input  logic [DEPTH-1:0] match,
  output logic             any,
  output logic [IDX_W-1:0] slot,
  output logic [DEPTH-1:0] above
);

  logic [DEPTH-1:0] first;

  always_comb begin
    slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      first[i] = match[i] & ~(|(match & low_mask(i)));
      above[i] = |(match & low_mask(i + 1));
      if (first[i]) begin
        slot = slot | IDX_W'(i);
      end
    end
    any = |match;
  end

endmodule

FILE: sv/keyed_list_with_index_shift.sv
// keyed ordered list: each request is captured with the cell compares, then the
// result is registered in the update cycle of the cell chain; a new request is taken
// only once the last one is updated; a waiting result holds back the update cycle
// reset clears the state, the entry count and the result valid flag; entry contents keep their bits
// depends on kl_pkg, kl_cell, kl_prio and assert_macros.svh
`include "assert_macros.svh"
module keyed_list_with_index_shift
  import kl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          req_type,
  input  logic [KEY_W-1:0]    var_id,
  input  logic [POS_W-1:0]    packet_index,
  input  logic signed [15:0]  shift_length,
  input  logic [15:0]         entry_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic                found,
  output logic [SLOT_W-1:0]   found_slot,
  output logic [KEY_W-1:0]    out_key,
  output logic [POS_W-1:0]    out_position,
  output logic [COUNT_W-1:0]  entry_count
);

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic [2:0]       r_req;
  logic [KEY_W-1:0] r_key;
  logic [POS_W-1:0] r_pos;
  logic [POS_W-1:0] r_amt;
  logic [DEPTH-1:0] r_match;
  logic [DEPTH-1:0] r_sel;
  logic             r_oor;

  logic [KEY_W-1:0] key_q [DEPTH];
  logic [POS_W-1:0] pos_q [DEPTH];
  logic [KEY_W-1:0] nkey  [DEPTH];
  logic [POS_W-1:0] npos  [DEPTH];
  logic [DEPTH-1:0] hit;
  logic [DEPTH-1:0] live;
  cell_ctl_t        ctl   [DEPTH];
  cell_bcast_t      bc;

  logic             any;
  logic [IDX_W-1:0] slot;
  logic [DEPTH-1:0] above;
  logic             full;
  logic             accept;
  logic             exec;

  logic [1:0]       res_status;
  logic             res_found;
  logic [IDX_W-1:0] res_slot;
  logic [KEY_W-1:0] rd_key;
  logic [POS_W-1:0] rd_pos;

  assign accept   = in_valid && !in_stall;
  assign exec     = (state == S_EXEC) && !(out_valid && out_stall);
  assign in_stall = (state != S_IDLE);
  assign full     = (count >= CNT_W'(DEPTH));

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_top
      assign nkey[i] = '0;
      assign npos[i] = '0;
    end else begin : g_mid
      assign nkey[i] = key_q[i + 1];
      assign npos[i] = pos_q[i + 1];
    end
    assign live[i] = (CNT_W'(i) < count);
    kl_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .bc       (bc),
      .probe    (var_id),
      .next_key (nkey[i]),
      .next_pos (npos[i]),
      .key      (key_q[i]),
      .pos      (pos_q[i]),
      .hit      (hit[i])
    );
  end

  kl_prio u_prio (
    .match (r_match),
    .any   (any),
    .slot  (slot),
    .above (above)
  );

  always_comb begin
    bc.shift_on = exec && (req_t'(r_req) == REQ_SHIFT);
    bc.key      = r_key;
    bc.pos      = r_pos;
    bc.amount   = r_amt;
    rd_key      = '0;
    rd_pos      = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].live      = live[i];
      ctl[i].load_new  = exec && (req_t'(r_req) == REQ_APPEND) && !full &&
                         (CNT_W'(i) == count);
      ctl[i].load_next = exec && (req_t'(r_req) == REQ_REMOVE) && above[i];
      if (r_sel[i]) begin
        rd_key = rd_key | key_q[i];
        rd_pos = rd_pos | pos_q[i];
      end
    end
  end

  always_comb begin
    count_next = count;
    res_status = ST_OK;
    res_found  = 1'b0;
    res_slot   = '0;
    case (req_t'(r_req))
      REQ_APPEND: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      REQ_FIND: begin
        res_found = any;
        res_slot  = slot;
      end
      REQ_REMOVE: begin
        res_found = any;
        res_slot  = slot;
        if (any) begin
          count_next = count - CNT_W'(1);
        end
      end
      REQ_SHIFT: begin
        res_status = ST_OK;
      end
      REQ_READ: begin
        if (r_oor) begin
          res_status = ST_OOR;
        end
      end
      REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // request capture with the cell compares
  always_ff @(posedge clk) begin
    if (accept) begin
      r_req <= req_type;
      r_key <= var_id;
      r_pos <= packet_index;
      r_amt <= shift_length;
      r_oor <= (32'(entry_index) >= 32'(count));
      for (int i = 0; i < DEPTH; i++) begin
        r_match[i] <= hit[i] && live[i];
        r_sel[i]   <= (32'(entry_index) == 32'(i)) && live[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status       <= res_status;
      found        <= res_found;
      found_slot   <= SLOT_W'(res_slot);
      out_key      <= (req_t'(r_req) == REQ_READ) ? rd_key : '0;
      out_position <= (req_t'(r_req) == REQ_READ) ? rd_pos : '0;
      entry_count  <= COUNT_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (exec) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `KL_NEVER(a_count_max, count > CNT_W'(DEPTH), "entry count above depth")
  `KL_ASSERT(a_accept_exec, accept |=> state == S_EXEC, "transfer not followed by update state")
  `KL_ASSERT(a_exec_result, exec |=> out_valid && !exec, "update cycle gave no result")
  `KL_ASSERT(a_clear, exec && (r_req == REQ_CLEAR) |=> count == '0, "clear left entries")

endmodule

FILE: verif/keyed_list_with_index_shift_test.sv
`timescale 1ns / 100ps
// self-checking testbench for keyed_list_with_index_shift: directed and random requests
// against a shadow copy of the list kept in a small scoreboard class
// depends on kl_pkg and the keyed_list_with_index_shift rtl
module keyed_list_with_index_shift_test;
  import kl_pkg::*;

  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 650;
  localparam int CALM_ITEMS = 100;
  localparam int HOLD_AT_ITEM = 200;
  localparam int LONG_HOLD = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   key;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_NOISE} mix_t;

  class keyed_list_shadow;
    logic [KEY_W-1:0] keys[DEPTH];
    logic [POS_W-1:0] positions[DEPTH];
    int held;
    int mismatches;
    list_result_t pending_results[$];

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function void note_request(logic [2:0] kind, logic [KEY_W-1:0] key,
                               logic [POS_W-1:0] ref_pos, logic [15:0] amount,
                               logic [15:0] slot_sel);
      list_result_t r;
      int hit;
      r = '0;
      hit = -1;
      if (kind == REQ_FIND || kind == REQ_REMOVE) begin
        for (int i = 0; i < held; i++) begin
          if (hit < 0 && keys[i] == key) hit = i;
        end
      end
      case (kind)
        REQ_APPEND: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            keys[held] = key;
            positions[held] = ref_pos;
            held++;
          end
        end
        REQ_FIND: begin
          if (hit >= 0) begin
            r.found = 1'b1;
            r.slot = hit[SLOT_W-1:0];
          end
        end
        REQ_REMOVE: begin
          if (hit >= 0) begin
            r.found = 1'b1;
            r.slot = hit[SLOT_W-1:0];
            for (int i = hit; i < held - 1; i++) begin
              keys[i] = keys[i + 1];
              positions[i] = positions[i + 1];
            end
            held--;
          end
        end
        REQ_SHIFT: begin
          for (int i = 0; i < held; i++) begin
            if (positions[i] > ref_pos) positions[i] = positions[i] + amount;
          end
        end
        REQ_READ: begin
          if (slot_sel >= held) begin
            r.status = ST_OOR;
          end else begin
            r.key = keys[slot_sel];
            r.position = positions[slot_sel];
          end
        end
        REQ_CLEAR: begin
          held = 0;
        end
        default: begin
        end
      endcase
      r.count = held[COUNT_W-1:0];
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s expected %0h actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("found", 16'(want.found), 16'(got.found));
      compare_field("found_slot", 16'(want.slot), 16'(got.slot));
      compare_field("out_key", want.key, got.key);
      compare_field("out_position", want.position, got.position);
      compare_field("entry_count", 16'(want.count), 16'(got.count));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] req_type = '0;
  logic [KEY_W-1:0] var_id = '0;
  logic [POS_W-1:0] packet_index = '0;
  logic signed [15:0] shift_length = '0;
  logic [15:0] entry_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic found;
  logic [SLOT_W-1:0] found_slot;
  logic [KEY_W-1:0] out_key;
  logic [POS_W-1:0] out_position;
  logic [COUNT_W-1:0] entry_count;

  list_result_t observed;
  keyed_list_shadow shadow;
  logic hold_output = 1'b0;
  logic hold_done = 1'b0;
  logic calm_tail = 1'b0;
  int sender_gap_odds = 2;
  int quiet_cycles = 0;

  keyed_list_with_index_shift uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .var_id(var_id),
    .packet_index(packet_index),
    .shift_length(shift_length),
    .entry_index(entry_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .found(found),
    .found_slot(found_slot),
    .out_key(out_key),
    .out_position(out_position),
    .entry_count(entry_count)
  );

  assign observed = {status, found, found_slot, out_key, out_position, entry_count};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(input logic [2:0] kind, input logic [15:0] key,
                           input logic [15:0] pos, input logic [15:0] amount,
                           input logic [15:0] slot);
    if (!calm_tail && sender_gap_odds != 0 && $urandom_range(0, 9) < sender_gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    var_id <= key;
    packet_index <= pos;
    shift_length <= amount;
    entry_index <= slot;
    do @(posedge clk); while (in_stall);
    shadow.note_request(kind, key, pos, amount, slot);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) shadow.check_result(observed);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver pacing: short stall bursts, free stretches and one long hold
  initial begin : receiver_pacing
    forever begin
      @(posedge clk);
      if (hold_output && !hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int sent;
    int seg_left;
    int roll;
    mix_t mix;
    logic [2:0] kind;
    logic [15:0] key;
    logic [15:0] pos;
    logic [15:0] amount;
    logic [15:0] slot;

    shadow = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_item(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_APPEND, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_APPEND, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(REQ_APPEND, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
    send_item(REQ_APPEND, 16'h1234, 16'h7FFF, 16'h0000, 16'h0000);
    send_item(REQ_FIND, 16'h1234, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_FIND, 16'hBEEF, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0003);
    send_item(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0004);
    send_item(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    send_item(REQ_SHIFT, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
    send_item(REQ_SHIFT, 16'h0000, 16'h7FFE, 16'h8000, 16'h0000);
    send_item(REQ_SHIFT, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000);
    send_item(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
    send_item(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0002);
    send_item(REQ_REMOVE, 16'h1234, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_REMOVE, 16'hBEEF, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_REMOVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_REMOVE, 16'h1234, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_SPARE_6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(REQ_SPARE_7, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_APPEND, 16'hA5A5, 16'h5A5A, 16'h0000, 16'h0000);
    send_item(REQ_FIND, 16'hA5A5, 16'h0000, 16'h0000, 16'h0000);

    // random part in segments; the first one fills the list past capacity
    sent = 0;
    mix = MIX_FILL;
    seg_left = 90;
    while (sent < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        mix = mix_t'($urandom_range(0, 3));
        seg_left = $urandom_range(30, 80);
        sender_gap_odds = $urandom_range(0, 3);
      end
      if (sent == HOLD_AT_ITEM) hold_output = 1'b1;
      if (sent == RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;

      roll = $urandom_range(0, 99);
      case (mix)
        MIX_FILL: kind = (roll < 90) ? REQ_APPEND : 3'($urandom_range(REQ_FIND, REQ_READ));
        MIX_BALANCED: begin
          if (roll < 25) kind = REQ_APPEND;
          else if (roll < 42) kind = REQ_FIND;
          else if (roll < 60) kind = REQ_REMOVE;
          else if (roll < 72) kind = REQ_SHIFT;
          else if (roll < 95) kind = REQ_READ;
          else kind = REQ_CLEAR;
        end
        MIX_DRAIN: begin
          if (roll < 10) kind = REQ_APPEND;
          else if (roll < 25) kind = REQ_FIND;
          else if (roll < 70) kind = REQ_REMOVE;
          else if (roll < 78) kind = REQ_SHIFT;
          else if (roll < 98) kind = REQ_READ;
          else kind = REQ_CLEAR;
        end
        default: kind = 3'($urandom_range(0, 7));
      endcase

      key = 16'($urandom);
      pos = 16'($urandom);
      amount = 16'($urandom);
      slot = 16'($urandom);
      if (mix != MIX_NOISE) begin
        roll = $urandom_range(0, 99);
        if (kind == REQ_APPEND) begin
          if (roll < 60) key = 16'($urandom_range(0, 15));
        end else if (roll < 60 && shadow.held > 0) begin
          key = shadow.keys[$urandom_range(0, shadow.held - 1)];
        end else if (roll < 90) begin
          key = 16'($urandom_range(0, 7));
        end
        if (kind == REQ_SHIFT && shadow.held > 0 && $urandom_range(0, 1) == 0)
          pos = shadow.positions[$urandom_range(0, shadow.held - 1)];
        if (kind == REQ_SHIFT && $urandom_range(0, 4) == 0)
          amount = 16'($urandom_range(0, 16)) - 16'd8;
        roll = $urandom_range(0, 99);
        if (roll < 70) slot = 16'($urandom_range(0, shadow.held));
        else if (roll < 80) slot = 16'($urandom_range(0, 2 * DEPTH));
      end

      send_item(kind, key, pos, amount, slot);
      sent++;
      seg_left--;
    end
    in_valid <= 1'b0;

    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+sv
sv/kl_pkg.sv
sv/kl_cell.sv
sv/kl_prio.sv
sv/keyed_list_with_index_shift.sv
verif/keyed_list_with_index_shift_test.sv
